### rtl/sha1_pkg.sv
// shared types, constants and a helper function for the sha-1 engine
package sha1_pkg;

	localparam int WORD_W  = 32;
	localparam int CNT_W   = 3;
	localparam int IDX_W   = 3;
	localparam int NUM_H   = 5;
	localparam int BLK_W   = 16;
	localparam int ROUNDS  = 80;
	localparam int RND_W   = 7;
	localparam int POS_W   = 4;
	localparam int LEN_W   = 64;

	typedef logic [WORD_W-1:0] word_t;

	// initial chaining values h0..h4
	localparam word_t IV [NUM_H] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	// round constants, one per group of twenty rounds
	localparam word_t K_0 = 32'h5A827999;
	localparam word_t K_1 = 32'h6ED9EBA1;
	localparam word_t K_2 = 32'h8F1BBCDC;
	localparam word_t K_3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam word_t      MARK_WORD = {PAD_MARK, 24'h000000};

	localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(NUM_H - 1);
	localparam logic [POS_W-1:0] LEN_HI_POS  = POS_W'(BLK_W - 2);
	localparam logic [POS_W-1:0] LAST_POS    = POS_W'(BLK_W - 1);
	localparam logic [RND_W-1:0] LAST_RND    = RND_W'(ROUNDS - 1);

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ROUND = 5'b00010,
		ST_FOLD  = 5'b00100,
		ST_PAD   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	// next padding word to be pushed
	typedef enum logic [3:0] {
		PK_MARK  = 4'b0001,
		PK_ZERO  = 4'b0010,
		PK_LEN_LO = 4'b0100,
		PK_DONE  = 4'b1000
	} pad_kind_t;

	// keep the leading bytes of a partial final word and append the marker byte
	function automatic word_t pad_word(input word_t data, input logic [CNT_W-1:0] cnt);
		word_t res;
		unique case (cnt)
			3'd0:    res = MARK_WORD;
			3'd1:    res = {data[31:24], PAD_MARK, 16'h0000};
			3'd2:    res = {data[31:16], PAD_MARK, 8'h00};
			3'd3:    res = {data[31:8], PAD_MARK};
			default: res = data;
		endcase
		return res;
	endfunction

endpackage

### rtl/sha1_in_if.sv
// message word channel: valid, ready and word payload
interface sha1_in_if;
	import sha1_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [WORD_W-1:0]    data_word;
	logic [CNT_W-1:0]     byte_count;
	logic                 last;

	modport source (output valid, data_word, byte_count, last, input ready);
	modport sink   (input valid, data_word, byte_count, last, output ready);
endinterface

### rtl/sha1_out_if.sv
// digest word channel: valid, ready and digest payload
interface sha1_out_if;
	import sha1_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [WORD_W-1:0]    digest_word;
	logic [IDX_W-1:0]     word_index;
	logic                 last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

### rtl/sha1_hash_engine.sv
// sha-1 engine: word intake, one-round-per-cycle compression, padding and digest output
// a word that does not complete a block is only shifted into the window; a word that completes
//   one starts the compression (intake, 80 rounds, chain fold); the final word adds its padding
//   words at one a cycle, one or two compressions, then the five digest words
// the block rate is set by the single round adder that runs one of the 80 rounds each cycle;
//   no message word is taken while a block is being compressed
// reset: arst_n clears the sequencer, loads h0..h4, zeroes bit length and word position
module sha1_hash_engine (
	input  logic           clk,
	input  logic           arst_n,
	sha1_in_if.sink        in_ch,
	sha1_out_if.source     out_ch
);
	import sha1_pkg::*;

	state_t               state_q, state_d;
	pad_kind_t            pad_kind_q, pad_kind_d;
	logic                 pad_on_q, pad_on_d;
	logic [RND_W-1:0]     rnd_q;
	logic [POS_W-1:0]     pos_q;
	logic [LEN_W-1:0]     bitlen_q, bitlen_d;
	logic [IDX_W-1:0]     out_idx_q;
	word_t                chain_q [NUM_H];
	word_t                wv_q [NUM_H];
	word_t                win_q [BLK_W];

	logic                 in_acc, out_acc;
	logic                 push_en;
	word_t                push_data;
	logic                 load_wv;
	logic                 fold_en;
	logic                 chain_clr;
	logic [CNT_W-1:0]     cnt_clamp;
	logic [LEN_W-1:0]     len_inc;

	word_t                f_val, k_val, t_val, sched;

	assign in_acc  = in_ch.valid && in_ch.ready;
	assign out_acc = out_ch.valid && out_ch.ready;

	assign in_ch.ready        = (state_q == ST_IDLE);
	assign out_ch.valid       = (state_q == ST_OUT);
	assign out_ch.digest_word = chain_q[out_idx_q];
	assign out_ch.word_index  = out_idx_q;
	assign out_ch.last_word   = (out_idx_q == LAST_IDX);

	// clamp the byte count of a final word to four
	assign cnt_clamp = (in_ch.byte_count > 3'd4) ? 3'd4 : in_ch.byte_count;
	assign len_inc   = in_ch.last ? LEN_W'({cnt_clamp, 3'b000}) : LEN_W'(WORD_W);

	// sequencer
	always_comb begin
		state_d    = state_q;
		pad_kind_d = pad_kind_q;
		pad_on_d   = pad_on_q;
		bitlen_d   = bitlen_q;
		push_en    = 1'b0;
		push_data  = in_ch.data_word;
		load_wv    = 1'b0;
		fold_en    = 1'b0;
		chain_clr  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					push_en  = 1'b1;
					bitlen_d = bitlen_q + len_inc;
					if (in_ch.last) begin
						push_data  = pad_word(in_ch.data_word, cnt_clamp);
						pad_on_d   = 1'b1;
						pad_kind_d = (cnt_clamp == 3'd4) ? PK_MARK : PK_ZERO;
						state_d    = ST_PAD;
					end
					if (pos_q == LAST_POS) begin
						load_wv = 1'b1;
						state_d = ST_ROUND;
					end
				end
			end
			ST_PAD: begin
				push_en = 1'b1;
				unique case (pad_kind_q)
					PK_MARK: begin
						push_data  = MARK_WORD;
						pad_kind_d = PK_ZERO;
					end
					PK_ZERO: begin
						if (pos_q == LEN_HI_POS) begin
							push_data  = bitlen_q[LEN_W-1:WORD_W];
							pad_kind_d = PK_LEN_LO;
						end else begin
							push_data = '0;
						end
					end
					PK_LEN_LO: begin
						push_data  = bitlen_q[WORD_W-1:0];
						pad_kind_d = PK_DONE;
					end
					default: begin
						push_data = '0;
					end
				endcase
				if (pos_q == LAST_POS) begin
					load_wv = 1'b1;
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (rnd_q == LAST_RND) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				fold_en = 1'b1;
				if (!pad_on_q) begin
					state_d = ST_IDLE;
				end else if (pad_kind_q == PK_DONE) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_PAD;
				end
			end
			ST_OUT: begin
				if (out_acc && out_idx_q == LAST_IDX) begin
					chain_clr = 1'b1;
					pad_on_d  = 1'b0;
					bitlen_d  = '0;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// round function and constant by round group
	always_comb begin
		priority if (rnd_q < RND_W'(20)) begin
			f_val = (wv_q[1] & wv_q[2]) | (~wv_q[1] & wv_q[3]);
			k_val = K_0;
		end else if (rnd_q < RND_W'(40)) begin
			f_val = wv_q[1] ^ wv_q[2] ^ wv_q[3];
			k_val = K_1;
		end else if (rnd_q < RND_W'(60)) begin
			f_val = (wv_q[1] & wv_q[2]) | (wv_q[1] & wv_q[3]) | (wv_q[2] & wv_q[3]);
			k_val = K_2;
		end else begin
			f_val = wv_q[1] ^ wv_q[2] ^ wv_q[3];
			k_val = K_3;
		end
	end

	// shared round adder and message schedule tap
	assign t_val = {wv_q[0][26:0], wv_q[0][31:27]} + f_val + wv_q[4] + k_val + win_q[0];
	assign sched = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pad_kind_q <= PK_ZERO;
			pad_on_q   <= 1'b0;
			rnd_q      <= '0;
			pos_q      <= '0;
			bitlen_q   <= '0;
			out_idx_q  <= '0;
		end else begin
			state_q    <= state_d;
			pad_kind_q <= pad_kind_d;
			pad_on_q   <= pad_on_d;
			bitlen_q   <= bitlen_d;
			if (push_en) begin
				pos_q <= pos_q + 1'b1;
			end
			if (state_q == ST_ROUND) begin
				rnd_q <= (rnd_q == LAST_RND) ? '0 : rnd_q + 1'b1;
			end
			if (out_acc) begin
				out_idx_q <= (out_idx_q == LAST_IDX) ? '0 : out_idx_q + 1'b1;
			end
		end
	end

	// chaining hash, reloaded with the initial values after each digest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_H; i++) begin
				chain_q[i] <= IV[i];
			end
		end else if (chain_clr) begin
			for (int i = 0; i < NUM_H; i++) begin
				chain_q[i] <= IV[i];
			end
		end else if (fold_en) begin
			for (int i = 0; i < NUM_H; i++) begin
				chain_q[i] <= chain_q[i] + wv_q[i];
			end
		end
	end

	// working variables a..e
	always_ff @(posedge clk) begin
		if (load_wv) begin
			for (int i = 0; i < NUM_H; i++) begin
				wv_q[i] <= chain_q[i];
			end
		end else if (state_q == ST_ROUND) begin
			wv_q[0] <= t_val;
			wv_q[1] <= wv_q[0];
			wv_q[2] <= {wv_q[1][1:0], wv_q[1][31:2]};
			wv_q[3] <= wv_q[2];
			wv_q[4] <= wv_q[3];
		end
	end

	// block window as a 16-word shift line: words enter at the top, schedule refills it
	always_ff @(posedge clk) begin
		if (push_en || state_q == ST_ROUND) begin
			for (int i = 0; i < BLK_W - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[BLK_W-1] <= push_en ? push_data : {sched[30:0], sched[31]};
		end
	end

endmodule

### rtl/sha1_checker.sv
// port-level checker for the sha-1 engine, bound to the engine module
module sha1_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);

	// a stalled digest transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
		else $error("digest payload changed while stalled");

	// no intake while the digest is being delivered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready during digest output");

	// digest words follow in index order without gaps
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_word |=>
			out_valid && word_index == $past(word_index) + 3'd1)
		else $error("digest word index did not advance");

	// the final digest word closes the burst and carries index four
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_word |-> word_index == 3'd4 ##1 !out_valid)
		else $error("digest burst did not end after the last word");

endmodule

bind sha1_hash_engine sha1_checker u_sha1_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.digest_word (out_ch.digest_word),
	.word_index  (out_ch.word_index),
	.last_word   (out_ch.last_word)
);
